// File: rtl/core/dle_stuffed_frame_deframer_core_assert.svh
// Assertion macros for the DLE frame deframer core.
// Used by dsfd_step, which checks its own state; depends on nothing else.
`ifndef DLE_STUFFED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define DLE_STUFFED_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSFD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSFD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dsfd_pkg.sv
// Package for the DLE frame deframer core: framing codes, count width
// and the result record shared by the step logic and the result register.
package dsfd_pkg;

    localparam int unsigned MAX_LEN = 256;
    localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] ETX_CODE = 8'h03;

    localparam int unsigned TDATA_W = 32;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_index;
        logic [7:0] write_byte;
        logic       frame_done;
        logic [7:0] frame_length;
        logic       overflow;
    } result_t;

endpackage

// File: rtl/core/dsfd_in_stage.sv
// Input register of the DLE frame deframer core.
// Holds one received byte until the step logic takes it; uses no package.
module dsfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       take,
    output logic       valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign valid   = valid_reg;
    assign rx_byte = byte_reg;

endmodule

// File: rtl/core/dsfd_step.sv
// Deframing step of the DLE frame deframer core: byte history, frame flag,
// DLE parity and byte count. Depends on dsfd_pkg and the assertion header.
`include "dle_stuffed_frame_deframer_core_assert.svh"

module dsfd_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output dsfd_pkg::result_t res
);

    logic                       in_frame_reg;
    logic                       in_frame_next;
    logic [7:0]                 last_byte_reg;
    logic [7:0]                 last_byte_next;
    logic [7:0]                 before_last_reg;
    logic [7:0]                 before_last_next;
    logic                       parity_reg;
    logic                       parity_next;
    logic [dsfd_pkg::CNT_W-1:0] count_reg;
    logic [dsfd_pkg::CNT_W-1:0] count_next;

    logic                       is_dle;
    logic                       is_etx;
    logic [dsfd_pkg::CNT_W-1:0] cnt_inc;
    logic [dsfd_pkg::CNT_W-1:0] cnt_upd;
    logic [dsfd_pkg::CNT_W-1:0] len_cnt;
    logic [dsfd_pkg::CNT_W+7:0] idx_ext;
    logic [dsfd_pkg::CNT_W+7:0] len_ext;
    logic                       par_upd;
    logic                       hit_max;
    logic                       close;
    logic                       open;

    assign is_dle  = (rx_byte == dsfd_pkg::DLE_CODE);
    assign is_etx  = (rx_byte == dsfd_pkg::ETX_CODE);
    assign cnt_inc = count_reg + 1'b1;
    assign hit_max = (cnt_inc >= dsfd_pkg::CNT_W'(dsfd_pkg::MAX_LEN));
    assign par_upd = parity_reg ^ is_dle;
    // second DLE of a doubled pair pulls the count back: net no advance
    assign cnt_upd = (is_dle && !par_upd) ? count_reg : cnt_inc;
    assign close   = is_etx && (last_byte_reg == dsfd_pkg::DLE_CODE) && par_upd;
    assign len_cnt = cnt_upd - 1'b1;
    assign open    = !is_dle && (last_byte_reg == dsfd_pkg::DLE_CODE)
                     && (before_last_reg == dsfd_pkg::ETX_CODE);
    assign idx_ext = {8'd0, count_reg};
    assign len_ext = {8'd0, len_cnt};

    always_comb
    begin
        res           = '0;
        in_frame_next = in_frame_reg;
        parity_next   = parity_reg;
        count_next    = count_reg;
        if (in_frame_reg)
        begin
            res.write_valid = 1'b1;
            res.write_index = idx_ext[7:0];
            res.write_byte  = last_byte_reg;
            res.overflow    = hit_max;
            res.frame_done  = close;
            if (close)
            begin
                res.frame_length = len_ext[7:0];
            end
            in_frame_next = !(hit_max || close);
            parity_next   = par_upd;
            count_next    = cnt_upd;
        end
        else if (open)
        begin
            in_frame_next = 1'b1;
            parity_next   = 1'b0;
            count_next    = '0;
        end
    end

    assign last_byte_next   = fire ? rx_byte : last_byte_reg;
    assign before_last_next = fire ? last_byte_reg : before_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            last_byte_reg   <= dsfd_pkg::ETX_CODE;
            before_last_reg <= dsfd_pkg::DLE_CODE;
            parity_reg      <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            last_byte_reg   <= last_byte_next;
            before_last_reg <= before_last_next;
            if (fire)
            begin
                in_frame_reg <= in_frame_next;
                parity_reg   <= parity_next;
                count_reg    <= count_next;
            end
        end
    end

    `DSFD_ASSERT_IMP(a_count_bound, 1'b1,
        count_reg <= dsfd_pkg::CNT_W'(dsfd_pkg::MAX_LEN), "byte count beyond MAX_LEN")
    `DSFD_ASSERT_IMP(a_done_in_frame, res.frame_done || res.overflow,
        res.write_valid, "frame end reported outside a frame")
    `DSFD_ASSERT_NXT(a_done_leaves, fire && (res.frame_done || res.overflow),
        !in_frame_reg, "frame still open after it ended")
    `DSFD_ASSERT_NXT(a_open_clears, fire && !in_frame_reg && open,
        in_frame_reg && (count_reg == '0) && !parity_reg, "frame opened with stale count")

endmodule

// File: rtl/core/dsfd_out_stage.sv
// Result register of the DLE frame deframer core: holds one result item
// until the sink takes it. Depends on dsfd_pkg for the result record.
module dsfd_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  dsfd_pkg::result_t               res,
    output logic                            ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsfd_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    dsfd_pkg::result_t res_reg;

    assign ready      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {6'd0, res_reg.overflow, res_reg.frame_length,
                       res_reg.write_byte, res_reg.write_index, res_reg.write_valid};

endmodule

// File: rtl/core/dle_stuffed_frame_deframer_core.sv
// DLE frame deframer core: takes one received byte per item and returns one
// result item per byte, reporting each kept payload byte with its index, the
// frame length on DLE ETX, and overflow when a frame reaches MAX_LEN bytes.
// Throughput is one item per clock while the sink is not stalled. An accepted byte
// passes the input register, then the deframing step and the result register,
// where its result goes valid. A stalled sink holds both registers.
module dle_stuffed_frame_deframer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] write_valid, [8:1] write_index, [16:9] write_byte,
    // [24:17] frame_length, [25] overflow, [31:26] zero
    output logic [dsfd_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast   // frame_done
);

    logic              take;
    logic              in_valid;
    logic [7:0]        rx_byte;
    logic              fire;
    dsfd_pkg::result_t res;

    dsfd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .valid    (in_valid),
        .rx_byte  (rx_byte)
    );

    // advance the held byte only when the result register has room
    assign fire = in_valid && take;

    dsfd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (rx_byte),
        .res     (res)
    );

    dsfd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .ready    (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for dle_stuffed_frame_deframer_core: drives a byte stream of stuffed
// frames, noise and broken frames, and checks every result item against a predictor.
// Depends on dsfd_pkg and the core RTL only.
module tb_top;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AT     = 400;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic [7:0]        rx;
        bit                typed;
        dsfd_pkg::result_t res;
    } plan_row_t;

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = 8'h00;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dsfd_pkg::TDATA_W-1:0]   m_tdata;
    logic                           m_tlast;

    plan_row_t         rx_plan[$];
    dsfd_pkg::result_t expected_results[$];

    // predictor state
    bit         in_frame;
    logic [7:0] last_rx;
    logic [7:0] prev_rx;
    bit         dle_odd;
    int         frame_count;

    int accepted_in  = 0;
    int offer_idx    = -1;
    int quiet_from   = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int holdoff_left = 0;
    bit holdoff_done = 0;
    bit sink_ready;
    int stall_cycles = 0;
    int errors       = 0;
    int n_results    = 0;
    int n_writes     = 0;
    int n_frames     = 0;
    int n_overflows  = 0;
    int n_both       = 0;
    dsfd_pkg::result_t want;

    dle_stuffed_frame_deframer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic dsfd_pkg::result_t mk_result(bit wv, logic [7:0] idx, logic [7:0] wb,
                                                    bit done, logic [7:0] len, bit ovf);
        dsfd_pkg::result_t r;
        r.write_valid  = wv;
        r.write_index  = idx;
        r.write_byte   = wb;
        r.frame_done   = done;
        r.frame_length = len;
        r.overflow     = ovf;
        return r;
    endfunction

    // Advance the deframer state by one received byte and return its result item.
    function automatic dsfd_pkg::result_t deframe_step(logic [7:0] c);
        dsfd_pkg::result_t r;
        r = '0;
        if (in_frame)
        begin
            r.write_valid = 1'b1;
            r.write_index = frame_count[7:0];
            r.write_byte  = last_rx;
            frame_count++;
            if (frame_count >= int'(dsfd_pkg::MAX_LEN))
            begin
                r.overflow = 1'b1;
                in_frame   = 1'b0;
            end
            if (c == dsfd_pkg::DLE_CODE)
            begin
                dle_odd = !dle_odd;
                // second DLE of a doubled pair: store the pair as one byte
                if (!dle_odd && frame_count > 0)
                    frame_count--;
            end
            if (c == dsfd_pkg::ETX_CODE && last_rx == dsfd_pkg::DLE_CODE && dle_odd)
            begin
                r.frame_done   = 1'b1;
                r.frame_length = 8'(frame_count - 1);
                in_frame       = 1'b0;
            end
        end
        else if (c != dsfd_pkg::DLE_CODE && last_rx == dsfd_pkg::DLE_CODE
                 && prev_rx == dsfd_pkg::ETX_CODE)
        begin
            in_frame    = 1'b1;
            frame_count = 0;
            dle_odd     = 1'b0;
        end
        prev_rx = last_rx;
        last_rx = c;
        return r;
    endfunction

    task automatic push_byte(logic [7:0] b);
        plan_row_t row;
        row.rx    = b;
        row.typed = 1'b0;
        row.res   = '0;
        rx_plan.push_back(row);
    endtask

    task automatic push_checked(logic [7:0] b, dsfd_pkg::result_t r);
        plan_row_t row;
        row.rx    = b;
        row.typed = 1'b1;
        row.res   = r;
        rx_plan.push_back(row);
    endtask

    // Bias toward the framing codes so that stuffing and false closes show up often.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return dsfd_pkg::DLE_CODE;
        if (r == 2)
            return dsfd_pkg::ETX_CODE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Open a frame (ETX if needed, DLE, id) and stuff payload_len - 1 further bytes.
    task automatic open_frame(int payload_len);
        logic [7:0] b;
        if (rx_plan.size() == 0 || rx_plan[$].rx != dsfd_pkg::ETX_CODE)
            push_byte(dsfd_pkg::ETX_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        do
            b = pick_byte();
        while (b == dsfd_pkg::DLE_CODE);
        push_byte(b);
        for (int i = 1; i < payload_len; i++)
        begin
            b = pick_byte();
            push_byte(b);
            if (b == dsfd_pkg::DLE_CODE)
                push_byte(dsfd_pkg::DLE_CODE);
        end
    endtask

    task automatic add_frame(int payload_len);
        open_frame(payload_len);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::ETX_CODE);
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // Sender: change inputs on the falling edge, hold an offered item until taken.
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && offer_idx == accepted_in))
        begin
            if (send_gap == 0 && accepted_in < quiet_from && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 14);
            if (send_gap > 0 || accepted_in >= rx_plan.size())
            begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid  <= 1'b1;
                s_tdata   <= rx_plan[accepted_in].rx;
                offer_idx = accepted_in;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the core up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!holdoff_done && accepted_in >= HOLDOFF_AT)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                sink_ready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                sink_ready = 1'b0;
            end
            else if (accepted_in < quiet_from && $urandom_range(0, 7) == 0)
            begin
                recv_gap   = $urandom_range(1, 14) - 1;
                sink_ready = 1'b0;
            end
            else
                sink_ready = 1'b1;
            m_tready <= sink_ready;
        end
    end

    // Handshakes are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = deframe_step(rx_plan[accepted_in].rx);
                n_writes    += want.write_valid;
                n_frames    += want.frame_done;
                n_overflows += want.overflow;
                n_both      += want.frame_done & want.overflow;
                if (rx_plan[accepted_in].typed)
                    want = rx_plan[accepted_in].res;
                expected_results.push_back(want);
                accepted_in++;
            end
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expectation pending");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("write_valid", want.write_valid, m_tdata[0]);
                    check_field("write_index", want.write_index, m_tdata[8:1]);
                    check_field("write_byte", want.write_byte, m_tdata[16:9]);
                    check_field("frame_done", want.frame_done, m_tlast);
                    check_field("frame_length", want.frame_length, m_tdata[24:17]);
                    check_field("overflow", want.overflow, m_tdata[25]);
                    check_field("tdata_pad", 0, m_tdata[dsfd_pkg::TDATA_W-1:26]);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int iter;
        int r;

        in_frame    = 1'b0;
        last_rx     = dsfd_pkg::ETX_CODE;
        prev_rx     = dsfd_pkg::DLE_CODE;
        dle_odd     = 1'b0;
        frame_count = 0;

        // directed: first item after reset, extreme bytes, stuffing
        push_checked(dsfd_pkg::DLE_CODE, mk_result(0, 8'h00, 8'h00, 0, 8'h00, 0));
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(8'h80);
        push_byte(dsfd_pkg::DLE_CODE);
        push_checked(dsfd_pkg::ETX_CODE, mk_result(1, 8'd4, dsfd_pkg::DLE_CODE, 1, 8'd4, 0));
        // DLE DLE ETX outside a frame must not open one; a frame with ETX as id follows
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::ETX_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::ETX_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_checked(dsfd_pkg::ETX_CODE, mk_result(1, 8'd1, dsfd_pkg::DLE_CODE, 1, 8'd1, 0));
        // bare ETX in payload, then DLE DLE DLE ETX closes on the odd DLE
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(8'h00);
        push_byte(dsfd_pkg::ETX_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::DLE_CODE);
        push_byte(dsfd_pkg::ETX_CODE);

        iter = 0;
        while (rx_plan.size() < RANDOM_ITEMS + 22)
        begin
            // long frames: overflow with and without a close on the same byte
            if (iter == 4)
                add_frame(dsfd_pkg::MAX_LEN - 1);
            else if (iter == 12)
                add_frame(dsfd_pkg::MAX_LEN);
            else if (iter == 25)
                add_frame($urandom_range(dsfd_pkg::MAX_LEN - 6, dsfd_pkg::MAX_LEN + 2));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    add_frame($urandom_range(1, 20));
                else if (r < 85)
                begin
                    // broken: even DLE run before ETX leaves the frame open
                    open_frame($urandom_range(1, 8));
                    push_byte(dsfd_pkg::DLE_CODE);
                    push_byte(dsfd_pkg::DLE_CODE);
                    push_byte(dsfd_pkg::ETX_CODE);
                end
                else
                    repeat ($urandom_range(1, 10))
                        push_byte(pick_byte());
            end
            iter++;
        end
        quiet_from = rx_plan.size() * 85 / 100;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_in == rx_plan.size() && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in, %0d results checked: %0d payload writes, %0d frames closed",
                 accepted_in, n_results, n_writes, n_frames);
        $display("%0d overflows (%0d closing on the same byte), one %0d-cycle sink hold-off",
                 n_overflows, n_both, HOLDOFF_CYCLES);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
